FILE: hdl/ocm_pkg.sv
// ----------------------------------------------------------------------------
// Obstacle clearance map package
// Shared widths, codes, payload types and sequencer states.
// ----------------------------------------------------------------------------
package ocm_pkg;

   // Grid geometry
   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int COL_W    = 6;
   localparam int ROW_W    = 6;
   localparam int ADDR_W   = COL_W + ROW_W;
   localparam int NCELLS   = MAX_COLS * MAX_ROWS;
   localparam int CNT_W    = 7;

   // Arithmetic widths
   localparam int MUL_W  = 19;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SQ_W   = 32;
   localparam int DIST_W = 16;

   // Configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CWIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHEIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DANGER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR  = 3'd5;

   // Operation codes
   localparam logic [1:0] OP_WRITE     = 2'd0;
   localparam logic [1:0] OP_RECOMPUTE = 2'd1;
   localparam logic [1:0] OP_READ      = 2'd2;

   // Cell classes
   localparam logic [1:0] KIND_FAR    = 2'd0;
   localparam logic [1:0] KIND_DANGER = 2'd1;
   localparam logic [1:0] KIND_TRAV   = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [COL_W-1:0] cell_col;
      logic [ROW_W-1:0] cell_row;
      logic             occupied;
   } req_type;

   typedef struct packed {
      logic [1:0]        cell_class;
      logic [DIST_W-1:0] distance;
      logic [COL_W-1:0]  owner_col;
      logic [ROW_W-1:0]  owner_row;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DSQ, S_CSQ, S_CSQ2, S_RD, S_CHK, S_MY, S_MXX, S_MYY,
      S_CMP, S_FIN, S_SQW
   } state_type;

endpackage

FILE: hdl/ocm_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ocm_mul (
   input  logic                       clock,
   input  logic [ocm_pkg::MUL_W-1:0]  mul_a,
   input  logic [ocm_pkg::MUL_W-1:0]  mul_b,
   output logic [ocm_pkg::PROD_W-1:0] mul_p
);
   import ocm_pkg::*;

   logic [PROD_W-1:0] prod_ff;

   // Register the product.
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

FILE: hdl/ocm_sqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Bit-pair restoring square root, one result bit per cycle, floor result.
// ----------------------------------------------------------------------------
module ocm_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       sqrt_start,
   input  logic [ocm_pkg::SQ_W-1:0]   radicand,
   output logic                       sqrt_done,
   output logic [ocm_pkg::DIST_W-1:0] root
);
   import ocm_pkg::*;

   logic [4:0]        cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [SQ_W-1:0]   val_ff, val_in;
   logic [DIST_W:0]   rem_ff, rem_in;
   logic [DIST_W-1:0] root_ff, root_in;
   logic [DIST_W+2:0] rem_sh;
   logic [DIST_W+2:0] trial;

   // One step: bring down two bits and try to subtract 4*root+1.
   always_comb begin
      rem_sh  = {rem_ff, val_ff[SQ_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (sqrt_start) begin
         run_in  = 1'b1;
         cnt_in  = 5'(DIST_W - 1);
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (run_ff) begin
         val_in = {val_ff[SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (DIST_W+1)'(rem_sh - trial);
            root_in = {root_ff[DIST_W-2:0], 1'b1};
         end else begin
            rem_in  = (DIST_W+1)'(rem_sh);
            root_in = {root_ff[DIST_W-2:0], 1'b0};
         end
         if (cnt_ff == 5'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sqrt_done = done_ff;
   assign root      = root_ff;

endmodule

FILE: hdl/obstacle_clearance_map_top.sv
// ----------------------------------------------------------------------------
// Obstacle clearance map
// Occupancy grid with a brute-force clearance classifier and cell readout.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a clock edge with start high and busy low. A write item
// writes the occupied bit of one cell inside the grid in use. A read item gives
// one result on rsp_payload, marked by rsp_strobe for exactly one cycle, the
// cycle after it was taken; reads and writes may follow each other in every
// cycle. The receiver cannot stall the result channel.
// A recompute item holds busy high while one shared multiplier walks every
// cell of the grid in use against every cell. Setup squares the danger and
// clearance distances; then each pair is read and checked, and an occupied
// one also has its scaled dx and dy squared and compared. Each cell is then
// classified, after a square root for a traversable cell. A danger cell
// stops its scan early.
// Configuration registers are written through csr_we, csr_index and
// csr_wdata; write them only while busy is low and no result is due.
// After reset the block clears its occupancy and class memories, one cell a
// cycle, with busy high; configuration writes are still taken.
// ----------------------------------------------------------------------------
module obstacle_clearance_map_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  ocm_pkg::req_type              req_payload,
   output logic                          rsp_strobe,
   output ocm_pkg::rsp_type              rsp_payload,
   input  logic                          csr_we,
   input  logic [ocm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ocm_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import ocm_pkg::*;

   // Configuration registers
   logic [CNT_W-1:0]  cols_ff, rows_ff;
   logic [12:0]       cw_ff, ch_ff;
   logic [DIST_W-1:0] dd_ff, cd_ff;

   // Sequencer registers
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [COL_W-1:0]  m_ff, m_in, i_ff, i_in, oc_ff, oc_in;
   logic [ROW_W-1:0]  n_ff, n_in, j_ff, j_in, or_ff, or_in;
   logic              danger_ff, danger_in, found_ff, found_in;
   logic [SQ_W-1:0]   best_ff, best_in, dsq_ff, dsq_in, csq_ff, csq_in;
   logic [MUL_W-1:0]  dxs_ff, dxs_in, dys_ff, dys_in;
   logic [PROD_W-1:0] sq_ff, sq_in;

   // Read path registers
   logic              rd_valid_ff, in_grid_ff;
   logic [1:0]        kind_rd_ff;
   logic [DIST_W-1:0] dist_rd_ff;
   logic [ADDR_W-1:0] own_rd_ff;
   logic              occ_rd_ff;

   // Memories
   logic              occ_mem  [NCELLS];
   logic [1:0]        kind_mem [NCELLS];
   logic [DIST_W-1:0] dist_mem [NCELLS];
   logic [ADDR_W-1:0] own_mem  [NCELLS];

   // Shared units
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;
   logic              sqrt_start, sqrt_done;
   logic [DIST_W-1:0] root;

   // Combinational control
   logic [CNT_W-1:0]  nc, nr;
   logic              accept, in_grid_in;
   logic [ADDR_W-1:0] req_addr, occ_raddr, occ_waddr, kind_waddr;
   logic              occ_we, occ_wdata, kind_we, trav_we;
   logic [1:0]        kind_wdata;
   logic [COL_W-1:0]  dx;
   logic [ROW_W-1:0]  dy;
   logic [PROD_W:0]   d2;
   logic              last_i, last_j, last_m, last_n;

   ocm_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   ocm_sqrt u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .sqrt_start (sqrt_start),
      .radicand   (best_ff),
      .sqrt_done  (sqrt_done),
      .root       (root)
   );

   // Grid in use, limited to the physical size.
   assign nc       = (cols_ff > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cols_ff;
   assign nr       = (rows_ff > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_ff;
   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign req_addr = {req_payload.cell_col, req_payload.cell_row};
   assign in_grid_in = (CNT_W'(req_payload.cell_col) < nc)
                    && (CNT_W'(req_payload.cell_row) < nr);
   assign dx       = (m_ff > i_ff) ? (m_ff - i_ff) : (i_ff - m_ff);
   assign dy       = (n_ff > j_ff) ? (n_ff - j_ff) : (j_ff - n_ff);
   assign d2       = (PROD_W+1)'(sq_ff) + (PROD_W+1)'(mul_p);
   assign last_i   = (CNT_W'(i_ff) + 7'd1) == nc;
   assign last_j   = (CNT_W'(j_ff) + 7'd1) == nr;
   assign last_m   = (CNT_W'(m_ff) + 7'd1) == nc;
   assign last_n   = (CNT_W'(n_ff) + 7'd1) == nr;
   assign occ_raddr = {i_ff, j_ff};

   // Sequencer: next state, multiplier operands and memory writes.
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      m_in       = m_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      oc_in      = oc_ff;
      or_in      = or_ff;
      danger_in  = danger_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      dsq_in     = dsq_ff;
      csq_in     = csq_ff;
      dxs_in     = dxs_ff;
      dys_in     = dys_ff;
      sq_in      = sq_ff;
      mul_a      = '0;
      mul_b      = '0;
      sqrt_start = 1'b0;
      occ_we     = 1'b0;
      occ_waddr  = req_addr;
      occ_wdata  = req_payload.occupied;
      kind_we    = 1'b0;
      kind_waddr = {m_ff, n_ff};
      kind_wdata = KIND_FAR;
      trav_we    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            occ_we     = 1'b1;
            occ_waddr  = clr_ff;
            occ_wdata  = 1'b0;
            kind_we    = 1'b1;
            kind_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(NCELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && req_payload.op == OP_WRITE && in_grid_in) begin
               occ_we = 1'b1;
            end
            if (accept && req_payload.op == OP_RECOMPUTE) begin
               state_in = S_DSQ;
            end
         end
         S_DSQ: begin
            mul_a    = MUL_W'(dd_ff);
            mul_b    = MUL_W'(dd_ff);
            state_in = S_CSQ;
         end
         S_CSQ: begin
            dsq_in   = mul_p[SQ_W-1:0];
            mul_a    = MUL_W'(cd_ff);
            mul_b    = MUL_W'(cd_ff);
            state_in = S_CSQ2;
         end
         S_CSQ2: begin
            csq_in    = mul_p[SQ_W-1:0];
            m_in      = '0;
            n_in      = '0;
            i_in      = '0;
            j_in      = '0;
            danger_in = 1'b0;
            found_in  = 1'b0;
            state_in  = (nc == '0 || nr == '0) ? S_IDLE : S_RD;
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            mul_a = MUL_W'(dx);
            mul_b = MUL_W'(cw_ff);
            if (occ_rd_ff) begin
               state_in = S_MY;
            end else if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  state_in = S_FIN;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_RD;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_MY: begin
            dxs_in   = mul_p[MUL_W-1:0];
            mul_a    = MUL_W'(dy);
            mul_b    = MUL_W'(ch_ff);
            state_in = S_MXX;
         end
         S_MXX: begin
            dys_in   = mul_p[MUL_W-1:0];
            mul_a    = dxs_ff;
            mul_b    = dxs_ff;
            state_in = S_MYY;
         end
         S_MYY: begin
            sq_in    = mul_p;
            mul_a    = dys_ff;
            mul_b    = dys_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (d2 < (PROD_W+1)'(dsq_ff)) begin
               danger_in = 1'b1;
               state_in  = S_FIN;
            end else begin
               if (d2 < (PROD_W+1)'(csq_ff)
                   && (!found_ff || d2 < (PROD_W+1)'(best_ff))) begin
                  found_in = 1'b1;
                  best_in  = d2[SQ_W-1:0];
                  oc_in    = i_ff;
                  or_in    = j_ff;
               end
               if (last_j) begin
                  j_in = '0;
                  if (last_i) begin
                     state_in = S_FIN;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_RD;
                  end
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_FIN, S_SQW: begin
            if (state_ff == S_FIN && !danger_ff && found_ff) begin
               sqrt_start = 1'b1;
               state_in   = S_SQW;
            end else if (state_ff == S_FIN || sqrt_done) begin
               // Classify this cell and move on to the next one.
               kind_we    = 1'b1;
               kind_wdata = danger_ff ? KIND_DANGER : (found_ff ? KIND_TRAV : KIND_FAR);
               trav_we    = (state_ff == S_SQW);
               danger_in  = 1'b0;
               found_in   = 1'b0;
               i_in       = '0;
               j_in       = '0;
               state_in   = S_RD;
               if (last_n) begin
                  n_in = '0;
                  if (last_m) begin
                     state_in = S_IDLE;
                  end else begin
                     m_in = m_ff + 1'b1;
                  end
               end else begin
                  n_in = n_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         rd_valid_ff <= 1'b0;
         cols_ff     <= 7'd64;
         rows_ff     <= 7'd64;
         cw_ff       <= 13'd100;
         ch_ff       <= 13'd100;
         dd_ff       <= 16'd300;
         cd_ff       <= 16'd1000;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         rd_valid_ff <= accept && (req_payload.op == OP_READ);
         if (csr_we) begin
            case (csr_index)
               CSR_COLS:   cols_ff <= csr_wdata[CNT_W-1:0];
               CSR_ROWS:   rows_ff <= csr_wdata[CNT_W-1:0];
               CSR_CWIDTH: cw_ff   <= csr_wdata[12:0];
               CSR_CHEIGH: ch_ff   <= csr_wdata[12:0];
               CSR_DANGER: dd_ff   <= csr_wdata;
               CSR_CLEAR:  cd_ff   <= csr_wdata;
               default:    ;
            endcase
         end
      end
   end

   // Sequencer datapath registers.
   always_ff @(posedge clock) begin
      m_ff       <= m_in;
      n_ff       <= n_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      oc_ff      <= oc_in;
      or_ff      <= or_in;
      danger_ff  <= danger_in;
      found_ff   <= found_in;
      best_ff    <= best_in;
      dsq_ff     <= dsq_in;
      csq_ff     <= csq_in;
      dxs_ff     <= dxs_in;
      dys_ff     <= dys_in;
      sq_ff      <= sq_in;
      in_grid_ff <= in_grid_in;
   end

   // Occupancy memory.
   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[occ_waddr] <= occ_wdata;
      end
      occ_rd_ff <= occ_mem[occ_raddr];
   end

   // Class memory.
   always_ff @(posedge clock) begin
      if (kind_we) begin
         kind_mem[kind_waddr] <= kind_wdata;
      end
      kind_rd_ff <= kind_mem[req_addr];
   end

   // Distance and owner memories, written for traversable cells only.
   always_ff @(posedge clock) begin
      if (trav_we) begin
         dist_mem[{m_ff, n_ff}] <= root;
         own_mem[{m_ff, n_ff}]  <= {oc_ff, or_ff};
      end
      dist_rd_ff <= dist_mem[req_addr];
      own_rd_ff  <= own_mem[req_addr];
   end

   // Result formatting.
   always_comb begin
      rsp_payload = '0;
      if (!in_grid_ff) begin
         rsp_payload.cell_class = KIND_DANGER;
      end else begin
         rsp_payload.cell_class = kind_rd_ff;
         if (kind_rd_ff == KIND_TRAV) begin
            rsp_payload.distance  = dist_rd_ff;
            rsp_payload.owner_col = own_rd_ff[ADDR_W-1:ROW_W];
            rsp_payload.owner_row = own_rd_ff[ROW_W-1:0];
         end
      end
   end

   assign rsp_strobe = rd_valid_ff;

endmodule

FILE: hdl/ocm_checker.sv
// ----------------------------------------------------------------------------
// Obstacle clearance map checker
// Port-level assertions on item handling, bound to the top level.
// ----------------------------------------------------------------------------
module ocm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input ocm_pkg::req_type              req_payload,
   input logic                          rsp_strobe,
   input ocm_pkg::rsp_type              rsp_payload,
   input logic                          csr_we,
   input logic [ocm_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [ocm_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import ocm_pkg::*;

   // A result only follows an accepted read item.
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_payload.op == OP_READ))
      else $error("result without a read item");

   // Every accepted read item gives a result in the next cycle.
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.op == OP_READ) |=> rsp_strobe)
      else $error("read item lost");

   // A recompute item makes the block busy.
   a_recompute_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.op == OP_RECOMPUTE) |=> busy)
      else $error("recompute did not start");

   // Only traversable cells carry a distance and an owner.
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.cell_class != KIND_TRAV) |->
      (rsp_payload.distance == '0 && rsp_payload.owner_col == '0
       && rsp_payload.owner_row == '0))
      else $error("distance or owner on a non-traversable cell");

endmodule

bind obstacle_clearance_map_top ocm_checker u_ocm_checker (.*);
